// File: rtl/swr_pkg.sv
package swr_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int SUM_W      = 26;
	localparam int RMS_W      = 12;
	localparam int INTERVAL_W = 16;
	// The scaled mean square (sum * 256 / WINDOW) never exceeds 255 * 255 * 256.
	localparam int QUO_W      = 2 * RMS_W;
	localparam int FRAC_SHIFT = 8;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             full;
	} report_t;

endpackage

// File: rtl/swr_front.sv
module swr_front import swr_pkg::*; #(
	parameter int WINDOW = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_we,
	input  logic [INTERVAL_W-1:0] cfg_wdata,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  full,
	output logic                  rep_valid,
	output report_t               rep
);

	localparam int POS_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);

	logic [SAMPLE_W-1:0]   ring [WINDOW];
	logic [SAMPLE_W-1:0]   old_q;
	logic [POS_W-1:0]      pos_q;
	logic [FILL_W-1:0]     fill_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [INTERVAL_W-1:0] report_interval_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  valid_s1;
	logic                  report_s1;
	logic                  full_s1;
	logic                  old_ok_s1;
	logic [SAMPLE_W-1:0]   sample_s1;

	logic                  ring_full;
	logic [INTERVAL_W-1:0] interval_next;
	logic [SAMPLE_W-1:0]   old_sample;
	logic [2*SAMPLE_W-1:0] sq_new;
	logic [2*SAMPLE_W-1:0] sq_old;
	logic [SUM_W-1:0]      sum_next;
	logic [QCNT_W:0]       pending;

	assign ring_full     = (fill_q == FILL_W'(WINDOW));
	assign interval_next = interval_q + 1'b1;

	// Slots are written in order from zero, so before the ring has wrapped the
	// slot being replaced has never been written and its old value counts as zero.
	assign old_sample = old_ok_s1 ? old_q : '0;
	assign sq_new     = (2*SAMPLE_W)'(sample_s1) * (2*SAMPLE_W)'(sample_s1);
	assign sq_old     = (2*SAMPLE_W)'(old_sample) * (2*SAMPLE_W)'(old_sample);
	assign sum_next   = sum_q + SUM_W'(sq_new) - SUM_W'(sq_old);

	assign rep_valid = valid_s1 && report_s1;
	assign rep.sum   = sum_next;
	assign rep.full  = full_s1;

	// Reserve queue room for an item still in the second stage.
	assign pending = {1'b0, q_count} + (QCNT_W+1)'(valid_s1);
	assign full    = (pending >= (QCNT_W+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (accept) begin
			old_q       <= ring[pos_q];
			ring[pos_q] <= sample;
			sample_s1   <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q             <= '0;
			fill_q            <= '0;
			interval_q        <= '0;
			report_interval_q <= INTERVAL_RESET;
			sum_q             <= '0;
			valid_s1          <= 1'b0;
			report_s1         <= 1'b0;
			full_s1           <= 1'b0;
			old_ok_s1         <= 1'b0;
		end else begin
			if (cfg_we) begin
				report_interval_q <= cfg_wdata;
			end
			valid_s1 <= accept;
			if (valid_s1) begin
				sum_q <= sum_next;
			end
			if (accept) begin
				old_ok_s1 <= ring_full;
				full_s1   <= ring_full || (fill_q == FILL_W'(WINDOW - 1));
				if (pos_q == POS_W'(WINDOW - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
				if (!ring_full) begin
					fill_q <= fill_q + 1'b1;
				end
				if (interval_next == report_interval_q) begin
					report_s1  <= 1'b1;
					interval_q <= '0;
				end else begin
					report_s1  <= 1'b0;
					interval_q <= interval_next;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count passed the window size");
`endif

endmodule

// File: rtl/swr_fifo.sv
module swr_fifo import swr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  report_t           wr_data,
	input  logic              rd_en,
	output report_t           rd_data,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);

	report_t            slots [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign rd_data   = slots[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (count_q < QCNT_W'(QDEPTH)) || rd_en)
		else $error("report queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> not_empty)
		else $error("report queue read while empty");
`endif

endmodule

// File: rtl/swr_back.sv
module swr_back import swr_pkg::*; #(
	parameter int WINDOW = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  report_t          q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [RMS_W-1:0] rms_value,
	output logic             window_full
);

	localparam int ACC_W = SUM_W + FRAC_SHIFT + 1;
	localparam int CNT_W = $clog2(RMS_W);
	// Window size times the square of the top root bit.
	localparam logic [ACC_W-1:0] STEP_INIT = ACC_W'(WINDOW) << (2 * (RMS_W - 1));

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_SQRT = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   target_q;
	logic [ACC_W-1:0]   sqw_q;
	logic [ACC_W-1:0]   lin_q;
	logic [ACC_W-1:0]   step_q;
	logic [RMS_W-1:0]   root_q;
	logic               full_q;
	logic               out_valid_q;
	logic [RMS_W-1:0]   rms_q;
	logic               wf_q;

	logic [ACC_W-1:0]   trial;
	logic               take;
	logic               slot_free;

	// The result is the largest r with r * r * WINDOW <= sum * 256, so the mean
	// square is never formed by division. With root the bits settled so far and
	// b the bit under trial, sqw_q holds root^2 * WINDOW, lin_q holds
	// 2 * root * 2^b * WINDOW and step_q holds 4^b * WINDOW; their sum is the
	// scaled square of the trial root.
	assign trial = sqw_q + lin_q + step_q;
	assign take  = (trial <= target_q);

	assign slot_free   = !out_valid_q || pop;
	assign q_rd        = (state_q == B_IDLE) && q_not_empty;
	assign empty       = !out_valid_q;
	assign rms_value   = rms_q;
	assign window_full = wf_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				target_q <= {1'b0, q_data.sum, {FRAC_SHIFT{1'b0}}};
				sqw_q    <= '0;
				lin_q    <= '0;
				step_q   <= STEP_INIT;
				root_q   <= '0;
				full_q   <= q_data.full;
			end
			B_SQRT: begin
				if (take) begin
					sqw_q  <= trial;
					lin_q  <= (lin_q >> 1) + step_q;
					root_q <= {root_q[RMS_W-2:0], 1'b1};
				end else begin
					lin_q  <= lin_q >> 1;
					root_q <= {root_q[RMS_W-2:0], 1'b0};
				end
				step_q <= step_q >> 2;
			end
			B_DONE: begin
				if (slot_free) begin
					rms_q <= root_q;
					wf_q  <= full_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_not_empty) begin
						cnt_q   <= CNT_W'(RMS_W - 1);
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				B_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE && slot_free) |=> out_valid_q && state_q == B_IDLE)
		else $error("finished result was not placed in the output register");
	a_rms_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> rms_q <= RMS_W'(4080))
		else $error("RMS result out of range");
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> out_valid_q && $stable(rms_q) && $stable(wf_q))
		else $error("waiting result changed before transfer");
`endif

endmodule

// File: rtl/sliding_window_rms_unit.sv
// Moving-window RMS of an 8-bit converter stream.
// Input channel: drive sample and push; a transfer happens on a clock edge with
// push high and full low. The window stage takes a sample on every transfer, so
// samples can stream at one per cycle while full stays low.
// Every report_interval samples (0 means 65536) one result is produced:
// rms_value is floor(16 * sqrt(sum of squares / WINDOW)), 4 fractional bits,
// and window_full says WINDOW samples have been taken, the present one counted.
// Result channel: while empty is low the oldest result is on rms_value and
// window_full; it is transferred on an edge with pop high.
// A reporting sample's result passes the window stage and the queue, then a
// shared root unit that loads the sum, settles one root bit a cycle from the
// top and places the result in the output register once that is free. The unit
// takes a new sum from the queue only after it has placed the last result.
// A four-entry queue sits between the window stage and the root unit, so a
// stalled receiver holds results while samples keep entering until the queue
// fills; then full rises.
// Reset clears the window, the running sum and all counters and sets
// report_interval to 100; no clearing pass is needed. cfg_we writes it.
module sliding_window_rms_unit import swr_pkg::*; #(
	parameter int WINDOW = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_we,
	input  logic [INTERVAL_W-1:0] cfg_wdata,
	input  logic                  pop,
	output logic                  empty,
	output logic [RMS_W-1:0]      rms_value,
	output logic                  window_full
);

	logic              accept;
	logic              rep_valid;
	report_t           rep;
	report_t           q_data;
	logic              q_rd;
	logic              q_not_empty;
	logic [QCNT_W-1:0] q_count;

	assign accept = push && !full;

	swr_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_count   (q_count),
		.full      (full),
		.rep_valid (rep_valid),
		.rep       (rep)
	);

	swr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rep_valid),
		.wr_data   (rep),
		.rd_en     (q_rd),
		.rd_data   (q_data),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	swr_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.rms_value   (rms_value),
		.window_full (window_full)
	);

endmodule

// File: tb/rms_report_checker.sv
`timescale 1ns / 1ps

module rms_report_checker import swr_pkg::*; #(
	parameter int WINDOW = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_we,
	input  logic [INTERVAL_W-1:0] cfg_wdata,
	input  logic                  pop,
	input  logic                  empty,
	input  logic [RMS_W-1:0]      rms_value,
	input  logic                  window_full,
	output int                    mismatches,
	output int                    reports_pending
);

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef struct packed {
		logic [RMS_W-1:0] rms;
		logic             full;
	} rms_report_t;

	logic [SAMPLE_W-1:0]   window_ring [WINDOW];
	logic [SUM_W-1:0]      square_total;
	logic [POS_W-1:0]      slot;
	int                    fill;
	logic [INTERVAL_W-1:0] since_report;
	logic [INTERVAL_W-1:0] interval;
	rms_report_t           reports_due [$];
	rms_report_t           oldest;
	int                    err_count = 0;

	// Largest root whose square does not exceed v, built one bit at a time from the top.
	function automatic logic [RMS_W-1:0] root_floor(input logic [QUO_W-1:0] v);
		logic [RMS_W-1:0] root;
		logic [RMS_W-1:0] trial;
		root = '0;
		for (int b = RMS_W - 1; b >= 0; b--) begin
			trial = root | (RMS_W'(1) << b);
			if (32'(trial) * 32'(trial) <= 32'(v))
				root = trial;
		end
		return root;
	endfunction

	task automatic take_sample(input logic [SAMPLE_W-1:0] s);
		logic [2*SAMPLE_W-1:0]       sq_new;
		logic [2*SAMPLE_W-1:0]       sq_old;
		logic [INTERVAL_W-1:0]       next_count;
		logic [SUM_W+FRAC_SHIFT-1:0] scaled;
		rms_report_t                 rep;
		sq_new = (2*SAMPLE_W)'(s) * (2*SAMPLE_W)'(s);
		sq_old = (2*SAMPLE_W)'(window_ring[slot]) * (2*SAMPLE_W)'(window_ring[slot]);
		square_total = square_total + SUM_W'(sq_new) - SUM_W'(sq_old);
		window_ring[slot] = s;
		slot = (slot == POS_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
		if (fill < WINDOW)
			fill++;
		// A zero interval never matches before the counter wraps, so it acts as 65536.
		next_count = since_report + 1'b1;
		if (next_count == interval) begin
			scaled = {square_total, {FRAC_SHIFT{1'b0}}} / WINDOW;
			rep.rms = root_floor(QUO_W'(scaled));
			rep.full = (fill >= WINDOW);
			reports_due.push_back(rep);
			since_report = '0;
		end else begin
			since_report = next_count;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				window_ring[i] = '0;
			square_total = '0;
			slot = '0;
			fill = 0;
			since_report = '0;
			interval = INTERVAL_RESET;
			reports_due.delete();
		end else begin
			if (pop && !empty) begin
				if (reports_due.size() == 0) begin
					$error("rms result transfer with no result expected: %s %0d %s %0b",
						"rms_value", rms_value, "window_full", window_full);
					err_count++;
				end else begin
					oldest = reports_due.pop_front();
					if (rms_value !== oldest.rms) begin
						$error("rms_value: expected %0d, actual %0d", oldest.rms, rms_value);
						err_count++;
					end
					if (window_full !== oldest.full) begin
						$error("window_full: expected %0b, actual %0b", oldest.full, window_full);
						err_count++;
					end
				end
			end
			if (cfg_we)
				interval = cfg_wdata;
			if (push && !full)
				take_sample(sample);
		end
		mismatches <= err_count;
		reports_pending <= reports_due.size();
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import swr_pkg::*;

	localparam int WINDOW        = 1024;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS  = 500;
	localparam int HOLD_AFTER    = 50;
	localparam int HOLD_CYCLES   = 500;

	localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [18] = '{
		8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
		8'h80, 8'hFE, 8'hAA, 8'h55, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'h00
	};

	typedef enum int {
		SPREAD_UNIFORM,
		SPREAD_EXTREME,
		SPREAD_LOW,
		SPREAD_HIGH,
		SPREAD_FLAT
	} spread_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  cfg_we = 1'b0;
	logic [INTERVAL_W-1:0] cfg_wdata = '0;
	logic                  pop = 1'b0;
	logic                  empty;
	logic [RMS_W-1:0]      rms_value;
	logic                  window_full;
	logic                  steady = 1'b0;
	int                    mismatches;
	int                    reports_pending;

	always #5 clk = ~clk;

	sliding_window_rms_unit #(
		.WINDOW(WINDOW)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pop        (pop),
		.empty      (empty),
		.rms_value  (rms_value),
		.window_full(window_full)
	);

	rms_report_checker #(
		.WINDOW(WINDOW)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.sample         (sample),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.pop            (pop),
		.empty          (empty),
		.rms_value      (rms_value),
		.window_full    (window_full),
		.mismatches     (mismatches),
		.reports_pending(reports_pending)
	);

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_t spread,
		input logic [SAMPLE_W-1:0] level);
		case (spread)
			SPREAD_EXTREME: begin
				case ($urandom_range(3))
					0: return 8'h00;
					1: return 8'hFF;
					2: return 8'h01;
					default: return 8'hFE;
				endcase
			end
			SPREAD_LOW:  return SAMPLE_W'($urandom_range(15));
			SPREAD_HIGH: return SAMPLE_W'($urandom_range(255, 240));
			SPREAD_FLAT: return level;
			default:     return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Returns at the edge where the sample transfers; push stays high for a following sample.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] v);
		if (!steady && $urandom_range(99) < 6) begin
			push <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		push <= 1'b1;
		sample <= v;
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (reports_pending != 0);
	endtask

	task automatic set_interval(input logic [INTERVAL_W-1:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random pop gaps, and one long hold once a few dozen results have come.
	initial begin
		int  taken;
		int  hold_left;
		bit  held;
		taken = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				taken++;
			if (taken == HOLD_AFTER && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !(!steady && $urandom_range(99) < 6);
			end
		end
	end

	initial begin
		int                    sent;
		int                    span;
		int                    reps;
		int                    pause_at;
		spread_t               spread;
		logic [SAMPLE_W-1:0]   level;
		logic [INTERVAL_W-1:0] interval;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset interval of 100: edge codes first, then random; the one result comes
		// before the window has filled.
		foreach (EDGE_SAMPLES[i])
			offer_sample(EDGE_SAMPLES[i]);
		repeat (100 - $size(EDGE_SAMPLES))
			offer_sample(SAMPLE_W'($urandom));

		// Full scale on every sample fills the window and drives the RMS to its top.
		// The receiver hold falls in this stretch, so the block backs up to full.
		set_interval(16'd1);
		for (int i = 0; i < 1030; i++) begin
			offer_sample(8'hFF);
			if (i == 700)
				drain();
		end

		// No idling on either side while zeros start replacing the full-scale samples.
		steady <= 1'b1;
		repeat (100)
			offer_sample(8'h00);
		steady <= 1'b0;

		// A zero interval stays silent; the count it leaves runs on into the next
		// interval, which then reports after its remaining samples.
		set_interval(16'd0);
		repeat (150)
			offer_sample(SAMPLE_W'($urandom));
		set_interval(16'd200);
		repeat (50)
			offer_sample(pick_sample(SPREAD_HIGH, 8'h00));

		// Each phase sends whole intervals so the report counter starts from zero again.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: interval = INTERVAL_W'($urandom_range(8, 1));
				5, 6, 7, 8:    interval = INTERVAL_W'($urandom_range(60, 9));
				default:       interval = INTERVAL_W'($urandom_range(300, 61));
			endcase
			reps = $urandom_range((interval > 60) ? 2 : 6, 1);
			span = interval * reps;
			spread = spread_t'($urandom_range(4));
			level = SAMPLE_W'($urandom);
			pause_at = ($urandom_range(7) == 0) ? span / 2 : -1;
			set_interval(interval);
			for (int i = 0; i < span; i++) begin
				offer_sample(pick_sample(spread, level));
				if (i == pause_at)
					drain();
			end
			sent += span;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && reports_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
